[hdl/step_dir_pulse_generator_backlash_defines.svh]
// assertion macros used by the step/dir generator top level
`ifndef STEP_DIR_PULSE_GENERATOR_BACKLASH_DEFINES_SVH
`define STEP_DIR_PULSE_GENERATOR_BACKLASH_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SDPG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define SDPG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/sdpg_pkg.sv]
// shared types and constants of the step/dir pulse generator
package sdpg_pkg;

  localparam int POSITION_BITS = 32;
  localparam int BACKLASH_BITS = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;

  localparam logic [BACKLASH_BITS-1:0] BL_MAX = '1;

  localparam logic [2:0] MODE_TRACK    = 3'd0;
  localparam logic [2:0] MODE_SLEW_REQ = 3'd1;
  localparam logic [2:0] MODE_FAST_FWD = 3'd3;
  localparam logic [2:0] MODE_FAST_REV = 3'd4;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_REV  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BACKLASH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOME_SHIFT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FWD_LEVEL  = 3'd4;

  typedef struct packed {
    logic [15:0] backlash_amount;
    logic [3:0]  home_shift;
    logic [8:0]  fast_step_size;
    logic        square_wave;
    logic        forward_dir_level;
  } cfg_t;

  typedef struct packed {
    logic [POSITION_BITS-1:0] motor;
    logic [POSITION_BITS-1:0] target;
    logic [BACKLASH_BITS-1:0] bl_cnt;
    logic                     taking;
    logic [1:0]               dir_state;
    logic                     dir_level;
    logic                     phase;
    logic                     step;
  } state_t;

endpackage

[hdl/sdpg_next.sv]
// next-state logic for one timer tick
module sdpg_next (
  input  sdpg_pkg::state_t st_i,
  input  sdpg_pkg::cfg_t   cfg_i,
  input  logic [2:0]       mode_i,
  input  logic signed [1:0] rate_sign_i,
  input  logic             sync_enable_i,
  output sdpg_pkg::state_t st_o,
  output logic             pause_o
);
  import sdpg_pkg::*;

  localparam int PW = POSITION_BITS;
  localparam int BW = BACKLASH_BITS;

  logic [PW-1:0] rate_ext;
  logic [PW-1:0] step_sz;
  logic [PW-1:0] tgt_adv;
  logic [PW-1:0] tgt_fast;
  logic [BW-1:0] amount;
  logic [15:0]   home_sum;
  logic [15:0]   home_mask;
  logic          home_hit;
  logic          go_rev;
  logic          go_fwd;

  assign rate_ext  = {{(PW-2){rate_sign_i[1]}}, rate_sign_i};
  assign step_sz   = PW'(cfg_i.fast_step_size);
  assign amount    = (32'(cfg_i.backlash_amount) > 32'(BL_MAX)) ? BL_MAX
                                                                : BW'(cfg_i.backlash_amount);
  assign home_sum  = st_i.motor[15:0] + 16'(st_i.bl_cnt);
  assign home_mask = (16'd1 << cfg_i.home_shift) - 16'd1;
  assign home_hit  = (home_sum & home_mask) == 16'd0;

  // target advance is held off while backlash is being taken up
  assign tgt_adv = (sync_enable_i && !st_i.taking) ? st_i.target + rate_ext : st_i.target;
  assign go_rev  = ($signed(st_i.motor) > $signed(tgt_adv)) ||
                   (st_i.taking && st_i.dir_state == DIR_REV);
  assign go_fwd  = ($signed(tgt_adv) > $signed(st_i.motor)) ||
                   (st_i.taking && st_i.dir_state == DIR_FWD);

  always_comb begin
    st_o     = st_i;
    pause_o  = 1'b0;
    tgt_fast = st_i.target;
    if (!cfg_i.square_wave) begin
      st_o.step = 1'b0;
    end
    case (mode_i)
      MODE_TRACK, MODE_SLEW_REQ: begin
        if (mode_i == MODE_SLEW_REQ && home_hit && st_i.dir_state != DIR_NONE) begin
          pause_o = 1'b1;
        end else if (cfg_i.square_wave && !st_i.phase) begin
          st_o.step  = 1'b0;
          st_o.phase = 1'b1;
        end else if (go_rev) begin
          if (st_i.dir_state != DIR_REV) begin
            // reversal tick is lost, target stays put
            st_o.dir_state = DIR_REV;
            st_o.dir_level = ~cfg_i.forward_dir_level;
          end else begin
            if (st_i.bl_cnt != '0) begin
              st_o.bl_cnt = st_i.bl_cnt - BW'(1);
              st_o.taking = st_i.bl_cnt != BW'(1);
            end else begin
              st_o.motor  = st_i.motor - PW'(1);
              st_o.taking = 1'b0;
            end
            st_o.step   = 1'b1;
            st_o.target = tgt_adv;
            st_o.phase  = ~st_i.phase;
          end
        end else if (go_fwd) begin
          if (st_i.dir_state != DIR_FWD) begin
            st_o.dir_state = DIR_FWD;
            st_o.dir_level = cfg_i.forward_dir_level;
          end else begin
            if (st_i.bl_cnt < amount) begin
              st_o.bl_cnt = st_i.bl_cnt + BW'(1);
              st_o.taking = (st_i.bl_cnt + BW'(1)) < amount;
            end else begin
              st_o.motor  = st_i.motor + PW'(1);
              st_o.taking = 1'b0;
            end
            st_o.step   = 1'b1;
            st_o.target = tgt_adv;
            st_o.phase  = ~st_i.phase;
          end
        end else begin
          if (!st_i.taking) begin
            st_o.dir_state = DIR_NONE;
          end
          st_o.target = tgt_adv;
          st_o.phase  = ~st_i.phase;
        end
      end
      MODE_FAST_FWD, MODE_FAST_REV: begin
        if (st_i.phase || !cfg_i.square_wave) begin
          if (mode_i == MODE_FAST_FWD) begin
            tgt_fast = sync_enable_i ? st_i.target + step_sz : st_i.target;
            if ($signed(tgt_fast) > $signed(st_i.motor)) begin
              st_o.motor = st_i.motor + step_sz;
              st_o.step  = 1'b1;
            end
          end else begin
            tgt_fast = sync_enable_i ? st_i.target - step_sz : st_i.target;
            if ($signed(st_i.motor) > $signed(tgt_fast)) begin
              st_o.motor = st_i.motor - step_sz;
              st_o.step  = 1'b1;
            end
          end
          st_o.target = tgt_fast;
        end else begin
          st_o.step = 1'b0;
        end
        st_o.phase = ~st_i.phase;
      end
      default: begin
        // halted and unused modes leave the state alone, except that the step line is cleared when square wave is off
      end
    endcase
  end

endmodule

[hdl/step_dir_pulse_generator_backlash.sv]
// step/dir pulse generator with backlash take-up, top level
//
// Usage: each item on the input channel (in_valid_i / in_stall_o) is one
// step-timer tick carrying mode, rate sign and sync flag. Each tick yields
// exactly one result item on the output channel (out_valid_o / out_stall_i)
// with the step line level, direction pin level, pause flag, backlash flag
// and the motor and target positions after that tick.
// An accepted tick's result is registered and shows in the cycle after acceptance.
// Throughput is one tick per clock while the output is not stalled; the whole
// update is a single pass of add/compare logic between the state registers and
// the result register. When the receiver stalls, the result register holds
// and the block stalls its input only while that held result is still waiting.
// Configuration registers are written through cfg_valid_i / cfg_ready_o
// with cfg_index_i and cfg_data_i; ready is always high. The user must make
// writes only while no tick is in flight; the block does not enforce this.
// Reset clears positions, backlash and phase, sets the direction to forward
// with the pin at the forward level, and sets config registers to defaults
// (fast step size one, everything else zero). No result is pending after reset.
module step_dir_pulse_generator_backlash (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [2:0]                     mode_i,
  input  logic signed [1:0]              rate_sign_i,
  input  logic                           sync_enable_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           step_out_o,
  output logic                           dir_out_o,
  output logic                           pause_reached_o,
  output logic                           backlash_active_o,
  output logic signed [31:0]             motor_position_o,
  output logic signed [31:0]             target_position_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sdpg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sdpg_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import sdpg_pkg::*;

  `include "step_dir_pulse_generator_backlash_defines.svh"

  cfg_t   cfg_q;
  state_t st_q;
  state_t st_d;
  logic   pause_d;
  logic   in_accept;
  logic   cfg_we;
  logic   out_valid_q;
  logic   out_valid_d;
  logic [63:0] motor_wide;
  logic [63:0] target_wide;

  logic        res_step_q;
  logic        res_dir_q;
  logic        res_pause_q;
  logic        res_taking_q;
  logic [31:0] res_motor_q;
  logic [31:0] res_target_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_accept   = in_valid_i && !in_stall_o;

  sdpg_next u_next (
    .st_i          (st_q),
    .cfg_i         (cfg_q),
    .mode_i        (mode_i),
    .rate_sign_i   (rate_sign_i),
    .sync_enable_i (sync_enable_i),
    .st_o          (st_d),
    .pause_o       (pause_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.backlash_amount   <= '0;
      cfg_q.home_shift        <= '0;
      cfg_q.fast_step_size    <= 9'd1;
      cfg_q.square_wave       <= 1'b0;
      cfg_q.forward_dir_level <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index_i)
        CFG_BACKLASH:   cfg_q.backlash_amount   <= cfg_data_i[15:0];
        CFG_HOME_SHIFT: cfg_q.home_shift        <= cfg_data_i[3:0];
        CFG_FAST_STEP:  cfg_q.fast_step_size    <= cfg_data_i[8:0];
        CFG_SQUARE:     cfg_q.square_wave       <= cfg_data_i[0];
        CFG_FWD_LEVEL:  cfg_q.forward_dir_level <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.motor     <= '0;
      st_q.target    <= '0;
      st_q.bl_cnt    <= '0;
      st_q.taking    <= 1'b0;
      st_q.dir_state <= DIR_FWD;
      st_q.dir_level <= 1'b0;
      st_q.phase     <= 1'b0;
      st_q.step      <= 1'b0;
    end else if (cfg_we && cfg_index_i == CFG_FWD_LEVEL) begin
      // new forward level forces forward direction on the pin
      st_q.dir_state <= DIR_FWD;
      st_q.dir_level <= cfg_data_i[0];
    end else if (in_accept) begin
      st_q <= st_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign motor_wide  = 64'(st_d.motor);
  assign target_wide = 64'(st_d.target);

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_step_q   <= st_d.step;
      res_dir_q    <= st_d.dir_level;
      res_pause_q  <= pause_d;
      res_taking_q <= st_d.taking;
      res_motor_q  <= motor_wide[31:0];
      res_target_q <= target_wide[31:0];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign step_out_o        = res_step_q;
  assign dir_out_o         = res_dir_q;
  assign pause_reached_o   = res_pause_q;
  assign backlash_active_o = res_taking_q;
  assign motor_position_o  = $signed(res_motor_q);
  assign target_position_o = $signed(res_target_q);

  `SDPG_ASSERT_NOW(a_stall_needs_result, clk_i, rst_ni, in_stall_o, out_valid_q, "input stalled with no result held")
  `SDPG_ASSERT_NEXT(a_accept_gives_result, clk_i, rst_ni, in_accept, out_valid_q, "accepted item left no result")
  `SDPG_ASSERT_NOW(a_backlash_has_dir, clk_i, rst_ni, st_q.taking, st_q.dir_state != DIR_NONE, "backlash take-up without direction")
  `SDPG_ASSERT_NEXT(a_pause_holds_motor, clk_i, rst_ni, in_accept && pause_d, st_q.motor == $past(st_q.motor), "motor moved on a pause item")

endmodule

[verif/tb_step_dir_pulse_generator_backlash.sv]
// self-checking testbench for the step/dir pulse generator with backlash take-up
module tb_step_dir_pulse_generator_backlash;
  import sdpg_pkg::*;

  localparam logic [2:0] MODE_HALT   = 3'd2;
  localparam logic [2:0] MODE_RSVD_5 = 3'd5;
  localparam logic [2:0] MODE_RSVD_6 = 3'd6;
  localparam logic [2:0] MODE_RSVD_7 = 3'd7;

  localparam logic [1:0] RATE_ZERO = 2'b00;
  localparam logic [1:0] RATE_UP   = 2'b01;
  localparam logic [1:0] RATE_NEG2 = 2'b10;
  localparam logic [1:0] RATE_DOWN = 2'b11;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER [6] = '{CFG_BACKLASH, CFG_HOME_SHIFT,
      CFG_FAST_STEP, CFG_SQUARE, CFG_FWD_LEVEL, CFG_UNUSED};

  localparam int HOLD_OFF_CYCLES = 60;
  localparam int ROUNDS          = 9;
  localparam int TICKS_PER_ROUND = 100;

  typedef struct packed {
    logic        step;
    logic        dir;
    logic        pause;
    logic        backlash;
    logic [31:0] motor;
    logic [31:0] target;
  } motion_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] rate;
    logic       sync;
    logic       pinned;
    motion_t    want;
  } tick_row_t;

  localparam motion_t NO_PIN = '0;

  // opening sequence from reset settings; pinned rows carry the result by hand
  localparam tick_row_t DIRECTED_TICKS [22] = '{
    '{MODE_HALT,     RATE_ZERO, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0}},
    '{MODE_TRACK,    RATE_UP,   1'b1, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 32'd1, 32'd1}},
    '{MODE_TRACK,    RATE_DOWN, 1'b1, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 32'd1, 32'd1}},
    '{MODE_TRACK,    RATE_DOWN, 1'b1, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0}},
    '{MODE_SLEW_REQ, RATE_ZERO, 1'b0, 1'b1, '{1'b0, 1'b1, 1'b1, 1'b0, 32'd0, 32'd0}},
    '{MODE_TRACK,    RATE_ZERO, 1'b0, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0}},
    '{MODE_SLEW_REQ, RATE_UP,   1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0}},
    '{MODE_FAST_FWD, RATE_ZERO, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 32'd1, 32'd1}},
    '{MODE_FAST_REV, RATE_ZERO, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0}},
    '{MODE_FAST_FWD, RATE_ZERO, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0}},
    '{MODE_RSVD_5,   RATE_NEG2, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0}},
    '{MODE_RSVD_6,   RATE_UP,   1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0}},
    '{MODE_RSVD_7,   RATE_DOWN, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0}},
    '{MODE_TRACK,    RATE_NEG2, 1'b1, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0}},
    '{MODE_TRACK,    RATE_NEG2, 1'b1, 1'b1,
      '{1'b1, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFE}},
    '{MODE_TRACK,    RATE_ZERO, 1'b0, 1'b1,
      '{1'b1, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFFE, 32'hFFFF_FFFE}},
    '{MODE_SLEW_REQ, RATE_ZERO, 1'b1, 1'b1,
      '{1'b0, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFFE, 32'hFFFF_FFFE}},
    '{MODE_FAST_REV, RATE_UP,   1'b1, 1'b1,
      '{1'b1, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFFD, 32'hFFFF_FFFD}},
    '{MODE_TRACK,    RATE_UP,   1'b1, 1'b0, NO_PIN},
    '{MODE_TRACK,    RATE_UP,   1'b1, 1'b0, NO_PIN},
    '{MODE_SLEW_REQ, RATE_UP,   1'b1, 1'b0, NO_PIN},
    '{MODE_HALT,     RATE_DOWN, 1'b1, 1'b0, NO_PIN}
  };

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_stall_o;
  logic [2:0]            mode_i        = MODE_HALT;
  logic [1:0]            rate_sign_i   = RATE_ZERO;
  logic                  sync_enable_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i   = 1'b0;
  logic                  step_out_o;
  logic                  dir_out_o;
  logic                  pause_reached_o;
  logic                  backlash_active_o;
  logic signed [31:0]    motor_position_o;
  logic signed [31:0]    target_position_o;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = CFG_BACKLASH;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  step_dir_pulse_generator_backlash dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .mode_i,
    .rate_sign_i,
    .sync_enable_i,
    .out_valid_o,
    .out_stall_i,
    .step_out_o,
    .dir_out_o,
    .pause_reached_o,
    .backlash_active_o,
    .motor_position_o,
    .target_position_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // motion state mirror, starting from the reset values
  cfg_t                     settings_q = '{16'd0, 4'd0, 9'd1, 1'b0, 1'b0};
  logic [31:0]              motor_q    = '0;
  logic [31:0]              target_q   = '0;
  logic [BACKLASH_BITS-1:0] backlash_q = '0;
  logic                     taking_q   = 1'b0;
  logic [1:0]               dir_q      = DIR_FWD;
  logic                     level_q    = 1'b0;
  logic                     phase_q    = 1'b0;
  logic                     step_q     = 1'b0;

  motion_t motion_due [$];
  int      mismatch_cnt = 0;
  logic    pinned_on    = 1'b0;
  motion_t pinned_want  = '0;
  logic    hold_off_req = 1'b0;

  logic [2:0] run_mode = MODE_TRACK;
  logic [1:0] run_rate = RATE_UP;
  int         run_left = 0;

  function automatic motion_t next_motion(logic [2:0] mode, logic [1:0] rate, logic sync);
    logic [31:0] rate_ext;
    logic [31:0] home_mask;
    logic [31:0] prior_target;
    logic [31:0] fast_step;
    logic        pause;
    logic        lost;
    motion_t     res;
    rate_ext  = {{30{rate[1]}}, rate};
    fast_step = 32'(settings_q.fast_step_size);
    home_mask = (32'd1 << settings_q.home_shift) - 32'd1;
    pause     = 1'b0;
    lost      = 1'b0;
    if (!settings_q.square_wave) step_q = 1'b0;
    if (mode == MODE_TRACK || mode == MODE_SLEW_REQ) begin
      if (mode == MODE_SLEW_REQ && ((motor_q + 32'(backlash_q)) & home_mask) == 32'd0 &&
          dir_q != DIR_NONE) begin
        pause = 1'b1;
      end else if (settings_q.square_wave && !phase_q) begin
        step_q  = 1'b0;
        phase_q = 1'b1;
      end else begin
        prior_target = target_q;
        if (sync && !taking_q) target_q = target_q + rate_ext;
        if ($signed(motor_q) > $signed(target_q) || (taking_q && dir_q == DIR_REV)) begin
          // a reversal costs the tick and gives back the target advance
          if (dir_q != DIR_REV) begin
            target_q = prior_target;
            dir_q    = DIR_REV;
            level_q  = ~settings_q.forward_dir_level;
            lost     = 1'b1;
          end else begin
            if (backlash_q != '0) begin
              backlash_q = backlash_q - 1'b1;
              taking_q   = (backlash_q != '0);
            end else begin
              motor_q  = motor_q - 32'd1;
              taking_q = 1'b0;
            end
            step_q = 1'b1;
          end
        end else if ($signed(target_q) > $signed(motor_q) || (taking_q && dir_q == DIR_FWD)) begin
          if (dir_q != DIR_FWD) begin
            target_q = prior_target;
            dir_q    = DIR_FWD;
            level_q  = settings_q.forward_dir_level;
            lost     = 1'b1;
          end else begin
            // the amount already fits the counter, so no clamp is needed
            if (backlash_q < settings_q.backlash_amount) begin
              backlash_q = backlash_q + 1'b1;
              taking_q   = (backlash_q < settings_q.backlash_amount);
            end else begin
              motor_q  = motor_q + 32'd1;
              taking_q = 1'b0;
            end
            step_q = 1'b1;
          end
        end else if (!taking_q) begin
          dir_q = DIR_NONE;
        end
        if (!lost) phase_q = ~phase_q;
      end
    end else if (mode == MODE_FAST_FWD || mode == MODE_FAST_REV) begin
      if (phase_q || !settings_q.square_wave) begin
        if (mode == MODE_FAST_FWD) begin
          if (sync) target_q = target_q + fast_step;
          if ($signed(target_q) > $signed(motor_q)) begin
            motor_q = motor_q + fast_step;
            step_q  = 1'b1;
          end
        end else begin
          if (sync) target_q = target_q - fast_step;
          if ($signed(motor_q) > $signed(target_q)) begin
            motor_q = motor_q - fast_step;
            step_q  = 1'b1;
          end
        end
      end else begin
        step_q = 1'b0;
      end
      phase_q = ~phase_q;
    end
    res.step     = step_q;
    res.dir      = level_q;
    res.pause    = pause;
    res.backlash = taking_q;
    res.motor    = motor_q;
    res.target   = target_q;
    return res;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_BACKLASH:   settings_q.backlash_amount = data;
      CFG_HOME_SHIFT: settings_q.home_shift = data[3:0];
      CFG_FAST_STEP:  settings_q.fast_step_size = data[8:0];
      CFG_SQUARE:     settings_q.square_wave = data[0];
      CFG_FWD_LEVEL: begin
        settings_q.forward_dir_level = data[0];
        dir_q   = DIR_FWD;
        level_q = data[0];
      end
      default: ;
    endcase
  endfunction

  // runs of one mode and rate so positions travel and reverse; some pure noise
  function automatic tick_row_t random_row();
    tick_row_t   row;
    int unsigned pick;
    row = '0;
    if (run_left == 0) begin
      run_left = $urandom_range(1, 24);
      pick = $urandom_range(0, 9);
      run_rate = (pick < 4) ? RATE_UP : (pick < 8) ? RATE_DOWN : (pick < 9) ? RATE_ZERO : RATE_NEG2;
      pick = $urandom_range(0, 99);
      run_mode = (pick < 50) ? MODE_TRACK : (pick < 72) ? MODE_SLEW_REQ :
                 (pick < 83) ? MODE_FAST_FWD : (pick < 94) ? MODE_FAST_REV : MODE_HALT;
    end
    run_left--;
    if ($urandom_range(0, 9) == 0) begin
      row.mode = 3'($urandom);
      row.rate = 2'($urandom);
      row.sync = 1'($urandom);
    end else begin
      row.mode = run_mode;
      row.rate = run_rate;
      row.sync = ($urandom_range(0, 7) != 0);
    end
    return row;
  endfunction

  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic offer_tick(input tick_row_t row, input int unsigned gap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= row.mode;
    rate_sign_i   <= row.rate;
    sync_enable_i <= row.sync;
    pinned_on   = row.pinned;
    pinned_want = row.want;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (motion_due.size() != 0);
  endtask

  task automatic apply_settings(input logic [CFG_DATA_W-1:0] vals [6], input bit with_unused);
    for (int i = 0; i < 6; i++) begin
      if (i < 5 || with_unused) begin
        cfg_valid_i <= 1'b1;
        cfg_index_i <= CFG_ORDER[i];
        cfg_data_i  <= vals[i];
        do @(posedge clk_i); while (!cfg_ready_o);
        apply_reg(CFG_ORDER[i], vals[i]);
        @(negedge clk_i);
      end
    end
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin : scoreboard
    motion_t got;
    motion_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.step     = step_out_o;
        got.dir      = dir_out_o;
        got.pause    = pause_reached_o;
        got.backlash = backlash_active_o;
        got.motor    = motor_position_o;
        got.target   = target_position_o;
        if (motion_due.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("%0t: result with no tick pending", $time);
        end else begin
          want = motion_due.pop_front();
          if (got.step !== want.step || got.dir !== want.dir || got.pause !== want.pause ||
              got.backlash !== want.backlash || got.motor !== want.motor ||
              got.target !== want.target) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("%0t: mismatch step/dir/pause/bl exp %b%b%b%b got %b%b%b%b", $time,
                       want.step, want.dir, want.pause, want.backlash,
                       got.step, got.dir, got.pause, got.backlash);
              $display("  motor exp %0d got %0d, target exp %0d got %0d",
                       $signed(want.motor), $signed(got.motor),
                       $signed(want.target), $signed(got.target));
            end
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        want = next_motion(mode_i, rate_sign_i, sync_enable_i);
        if (pinned_on) want = pinned_want;
        motion_due.push_back(want);
      end
    end
  end

  initial begin : result_sink
    int unsigned burst;
    forever begin
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(10, 40)) @(negedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(0, 3) == 0);
        burst = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 24) : $urandom_range(1, 2);
        repeat (burst) @(negedge clk_i);
      end
    end
  end

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] vals [6];
    int unsigned           hs;
    int unsigned           fs;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DIRECTED_TICKS[i]) offer_tick(DIRECTED_TICKS[i], pick_gap(1'b0));
    drain();

    for (int round = 0; round < ROUNDS; round++) begin
      case (round)
        0: begin
          // backlash at the top of its range, home shift 8, fast step 256, flags set
          vals = '{16'hFFFF, 16'd8, 16'd256, 16'd1, 16'd1, 16'hFFFF};
        end
        1: begin
          // zero fast step, bottom of the rest, plus a write to an unused index
          vals = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'($urandom)};
        end
        default: begin
          vals[0] = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 6)) : 16'($urandom);
          hs = (round == 2) ? 15 :
               ($urandom_range(0, 7) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
          fs = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 256);
          vals[1] = {12'($urandom), 4'(hs)};
          vals[2] = {7'($urandom), 9'(fs)};
          vals[3] = {15'($urandom), 1'($urandom)};
          vals[4] = {15'($urandom), 1'($urandom)};
          vals[5] = '0;
        end
      endcase
      apply_settings(vals, round == 1);
      for (int n = 0; n < TICKS_PER_ROUND; n++) begin
        if (round == 3 && n == 40) begin
          // keep offering while the result side holds off, so the input backs up
          hold_off_req = 1'b1;
          while (hold_off_req) offer_tick(random_row(), 0);
        end
        if (round == 5 && n == 50) drain();
        offer_tick(random_row(), pick_gap(round == 2));
      end
      drain();
    end

    repeat (4) @(posedge clk_i);
    if (mismatch_cnt == 0 && motion_due.size() == 0) begin
      $display("** step_dir_pulse_generator_backlash: PASSED **");
    end else begin
      $display("** step_dir_pulse_generator_backlash: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("** step_dir_pulse_generator_backlash: FAILED **");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/sdpg_pkg.sv
hdl/sdpg_next.sv
hdl/step_dir_pulse_generator_backlash.sv
verif/tb_step_dir_pulse_generator_backlash.sv
